// ===== src/lrc_pkg.sv =====
// shared types and constants for the lru set-associative cache model
`default_nettype none
package lrc_pkg;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int COST_W     = 16;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 48;
    localparam int WAYS_CW    = 5;
    localparam int OUT_DATA_W = 264;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WALLOC     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WTHROUGH   = 3'd4;

    localparam logic [3:0] RST_SET_BITS   = 4'd6;
    localparam logic [3:0] RST_WAYS       = 4'd4;
    localparam logic [3:0] RST_BLOCK_BITS = 4'd4;

    localparam logic [3:0] BB_MIN = 4'd2;
    localparam logic [3:0] BB_MAX = 4'd10;
    localparam logic [COST_W-1:0] XFER_UNIT = 16'd100;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOK
    } t_state;

    typedef struct packed {
        logic              hit;
        logic              wb;
        logic [COST_W-1:0] cost;
    } t_lrc_res;
endpackage
`default_nettype wire

// ===== src/lrc_tag_ram.sv =====
// set memory holding tag, rank, dirty and valid of every way, with per-row init flags
`default_nettype none
module lrc_tag_ram #(
    parameter int SET_W = 8,
    parameter int ROW_W = 280
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [SET_W-1:0] i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [SET_W-1:0] i_wr_addr,
    input  wire logic [ROW_W-1:0] i_wr_data,
    output logic      [ROW_W-1:0] o_rd_data,
    output logic                  o_rd_init
);
    localparam int DEPTH = 1 << SET_W;

    logic [ROW_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_init;
    logic [ROW_W-1:0] r_rd_data;
    logic             r_rd_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init    <= '0;
            r_rd_init <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_init[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_init <= r_init[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_init = r_rd_init;
endmodule
`default_nettype wire

// ===== src/lrc_set_update.sv =====
// lookup, victim choice, recency update and cost of one access on a set row
`default_nettype none
module lrc_set_update #(
    parameter int MAX_WAYS = 8,
    parameter int TAG_W    = 30,
    parameter int RANK_W   = 3,
    parameter int ENT_W    = 35,
    parameter int ROW_W    = 280
) (
    input  wire logic                      i_row_init,
    input  wire logic [ROW_W-1:0]          i_row,
    input  wire logic [TAG_W-1:0]          i_tag,
    input  wire logic                      i_is_store,
    input  wire logic [MAX_WAYS-1:0]       i_way_use,
    input  wire logic                      i_wt,
    input  wire logic                      i_walloc,
    input  wire logic [lrc_pkg::COST_W-1:0] i_xfer,
    output logic      [ROW_W-1:0]          o_row,
    output lrc_pkg::t_lrc_res              o_res
);
    import lrc_pkg::*;

    localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);
    localparam logic [RANK_W:0]   OLDER_FILL = (RANK_W + 1)'(MAX_WAYS);

    logic [MAX_WAYS-1:0] vraw, vld, drt, match;
    logic [RANK_W-1:0]   rnk [MAX_WAYS];
    logic [TAG_W-1:0]    tg  [MAX_WAYS];
    logic                hit, free_ok, fill, do_touch, wb;
    logic [WIDX_W-1:0]   found, free_idx, victim, slot;
    logic [RANK_W-1:0]   best;
    logic [RANK_W:0]     older;
    logic [COST_W-1:0]   cost;
    logic [ENT_W-1:0]    ent;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            vraw[w]  = i_row_init & i_row[w*ENT_W];
            vld[w]   = vraw[w] & i_way_use[w];
            drt[w]   = i_row[w*ENT_W+1];
            rnk[w]   = i_row[w*ENT_W+2 +: RANK_W];
            tg[w]    = i_row[w*ENT_W+2+RANK_W +: TAG_W];
            match[w] = vld[w] && (tg[w] == i_tag);
        end
    end

    always_comb begin
        hit      = |match;
        free_ok  = |(i_way_use & ~vld);
        found    = '0;
        free_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                found = WIDX_W'(w);
            end
            if (i_way_use[w] && !vld[w]) begin
                free_idx = WIDX_W'(w);
            end
        end
        best   = '0;
        victim = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (vld[w] && (rnk[w] > best)) begin
                best   = rnk[w];
                victim = WIDX_W'(w);
            end
        end
    end

    always_comb begin
        fill     = !hit && !(i_is_store && !i_walloc);
        do_touch = hit || fill;
        slot     = hit ? found : (free_ok ? free_idx : victim);
        older    = hit ? {1'b0, rnk[found]} : OLDER_FILL;
        wb       = fill && !free_ok && !i_wt && drt[slot];
        if (hit) begin
            if (!i_is_store) begin
                cost = COST_W'(1);
            end else if (i_wt) begin
                cost = i_xfer + COST_W'(1);
            end else begin
                cost = COST_W'(2);
            end
        end else if (!fill) begin
            cost = i_xfer + COST_W'(1);
        end else begin
            cost = i_xfer + COST_W'(2) + (wb ? i_xfer : '0)
                 + ((i_is_store && i_wt) ? i_xfer : '0);
        end
    end

    always_comb begin
        ent = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            ent    = i_row[w*ENT_W +: ENT_W];
            ent[0] = vraw[w];
            if (do_touch) begin
                if (slot == WIDX_W'(w)) begin
                    ent[2 +: RANK_W] = '0;
                    if (fill) begin
                        ent[0]                  = 1'b1;
                        ent[1]                  = i_is_store && !i_wt;
                        ent[2+RANK_W +: TAG_W]  = i_tag;
                    end else if (i_is_store && !i_wt) begin
                        ent[1] = 1'b1;
                    end
                end else if (vld[w] && ({1'b0, rnk[w]} < older) && (rnk[w] < RANK_TOP)) begin
                    ent[2 +: RANK_W] = rnk[w] + RANK_W'(1);
                end
            end
            o_row[w*ENT_W +: ENT_W] = ent;
        end
    end

    assign o_res = '{hit: hit, wb: wb, cost: cost};
endmodule
`default_nettype wire

// ===== src/lru_set_assoc_cache_model.sv =====
// Set-associative cache tag model with true LRU replacement, top level.
// s_axis carries one access: tuser is the kind (0 load, 1 store), tdata the
// byte address. m_axis returns one result per access: hit, cycle cost, dirty
// write-back flag and the saturating running totals after this access.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// while no access is in flight.
// For each access, the set row is read from the set memory in the cycle of the
// transfer; then, in the lookup state, the row is looked up, updated and
// written back while the result is loaded into the output register.
// A new access is taken once the previous one has been written back; its
// result waits in the update cycle while the output register still holds an
// untaken result, so a stalled receiver holds the block after one more access.
// Reset clears the per-row init flags (all lines read invalid), the totals and
// the output valid, and restores the configuration reset values.
`default_nettype none
module lru_set_assoc_cache_model #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // address
    input  wire logic [((ADDR_BITS+7)/8)*8-1:0]  s_axis_tdata,
    // mode
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // hit, cycles_added, dirty_writeback, total_cycles, load_total,
    // load_hit_total, load_miss_total, store_total, store_hit_total,
    // store_miss_total, zero pad
    output logic [lrc_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [lrc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lrc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lrc_pkg::*;

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAG_W  = ADDR_BITS - 2;
    localparam int ENT_W  = TAG_W + RANK_W + 2;
    localparam int ROW_W  = MAX_WAYS * ENT_W;
    localparam int SH_W   = 5;

    logic [3:0] r_set_bits, r_ways, r_block_bits;
    logic       r_walloc, r_wt;

    t_state r_state, n_state;
    logic   s_xfer, commit, out_free;

    logic [3:0]         sb_c, bb_c;
    logic [WAYS_CW-1:0] ways_c;
    logic [MAX_WAYS-1:0] way_use;
    logic [ADDR_BITS-1:0] addr_in, addr_blk;
    logic [SET_W-1:0]   set_in, set_mask;
    logic [TAG_W-1:0]   tag_in;
    logic [COST_W-1:0]  xfer;

    logic [SET_W-1:0]   r_set;
    logic [TAG_W-1:0]   r_tag;
    logic               r_is_store;

    logic [ROW_W-1:0]   rd_row, wr_row;
    logic               rd_init;
    t_lrc_res           res;

    logic               r_out_valid;
    logic               r_hit, r_wb;
    logic [COST_W-1:0]  r_cost;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W:0]     sum_add;
    logic [CNT_W-1:0]   r_cnt [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= RST_SET_BITS;
            r_ways       <= RST_WAYS;
            r_block_bits <= RST_BLOCK_BITS;
            r_walloc     <= 1'b1;
            r_wt         <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data;
                CFG_WAYS:       r_ways       <= i_cfg_data;
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                CFG_WALLOC:     r_walloc     <= i_cfg_data[0];
                CFG_WTHROUGH:   r_wt         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    always_comb begin
        sb_c = (r_set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : r_set_bits;
        bb_c = (r_block_bits < BB_MIN) ? BB_MIN :
               ((r_block_bits > BB_MAX) ? BB_MAX : r_block_bits);
        if (r_ways == 4'd0) begin
            ways_c = WAYS_CW'(1);
        end else if ({1'b0, r_ways} > WAYS_CW'(MAX_WAYS)) begin
            ways_c = WAYS_CW'(MAX_WAYS);
        end else begin
            ways_c = {1'b0, r_ways};
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_use[w] = WAYS_CW'(w) < ways_c;
        end
        xfer     = XFER_UNIT << (bb_c - BB_MIN);
        addr_in  = s_axis_tdata[ADDR_BITS-1:0];
        addr_blk = addr_in >> bb_c;
        set_mask = ~({SET_W{1'b1}} << sb_c);
        set_in   = addr_blk[SET_W-1:0] & set_mask;
        tag_in   = TAG_W'(addr_in >> (SH_W'(bb_c) + SH_W'(sb_c)));
    end

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_LOOK;
            ST_LOOK: if (out_free)      n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        commit        = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_LOOK: commit        = out_free;
            default: ;
        endcase
    end

    assign s_xfer = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_set      <= set_in;
            r_tag      <= tag_in;
            r_is_store <= s_axis_tuser;
        end
    end

    lrc_tag_ram #(
        .SET_W (SET_W),
        .ROW_W (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_xfer),
        .i_rd_addr (set_in),
        .i_wr_en   (commit),
        .i_wr_addr (r_set),
        .i_wr_data (wr_row),
        .o_rd_data (rd_row),
        .o_rd_init (rd_init)
    );

    lrc_set_update #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W),
        .ENT_W    (ENT_W),
        .ROW_W    (ROW_W)
    ) u_upd (
        .i_row_init (rd_init),
        .i_row      (rd_row),
        .i_tag      (r_tag),
        .i_is_store (r_is_store),
        .i_way_use  (way_use),
        .i_wt       (r_wt),
        .i_walloc   (r_walloc),
        .i_xfer     (xfer),
        .o_row      (wr_row),
        .o_res      (res)
    );

    assign sum_add = {1'b0, r_sum} + (SUM_W + 1)'(res.cost);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            for (int k = 0; k < 6; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
                r_sum       <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
                for (int k = 0; k < 6; k++) begin
                    if ((k == (r_is_store ? 3 : 0) ||
                         k == (r_is_store ? (res.hit ? 4 : 5) : (res.hit ? 1 : 2))) &&
                        (r_cnt[k] != {CNT_W{1'b1}})) begin
                        r_cnt[k] <= r_cnt[k] + CNT_W'(1);
                    end
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_hit  <= res.hit;
            r_wb   <= res.wb;
            r_cost <= res.cost;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_cnt[5], r_cnt[4], r_cnt[3], r_cnt[2], r_cnt[1],
                            r_cnt[0], r_sum, r_wb, r_cost, r_hit};
endmodule
`default_nettype wire

// ===== src/lrc_checker.sv =====
// port-level checks of the lru cache model and their bind to the top level
`default_nettype none
module lrc_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [lrc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second access taken during update");

    a_wb_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> !m_axis_tdata[0])
        else $error("write-back reported on a hit");

    a_cost_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:1] != 16'd0)
        else $error("zero cycle cost");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind lru_set_assoc_cache_model lrc_checker u_lrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/lru_set_assoc_cache_model_checker.sv =====
// checker for the lru cache model: predicts each access result and compares it
`timescale 1ns / 100ps
`default_nettype none
module lru_set_assoc_cache_model_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    input  wire logic                               s_axis_tready,
    input  wire logic [31:0]                        s_axis_tdata,
    input  wire logic                               s_axis_tuser,
    input  wire logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic [lrc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [lrc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lrc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                      o_errors,
    output int                                      o_pending,
    output int                                      o_results,
    output int                                      o_hits,
    output int                                      o_writebacks
);
    import lrc_pkg::*;

    localparam int SETS_MAX  = 256;
    localparam int WAYS_MAX  = 8;
    localparam int LINES     = SETS_MAX * WAYS_MAX;
    localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    typedef struct {
        logic        hit;
        logic [15:0] cost;
        logic        wb;
        logic [47:0] total;
        logic [31:0] cnt [6];
    } t_access_res;

    logic [3:0]  set_bits_r, ways_r, block_bits_r;
    logic        walloc_r, wthrough_r;
    logic [63:0] tag_mem [LINES];
    logic        valid_mem [LINES];
    logic        dirty_mem [LINES];
    logic [2:0]  rank_mem [LINES];
    logic [47:0] cycle_sum;
    logic [31:0] acc_cnt [6];
    t_access_res expected_q [$];

    function automatic void bump_count(int k);
        if (acc_cnt[k] != CNT_SAT) acc_cnt[k] = acc_cnt[k] + 1;
    endfunction

    function automatic void make_recent(int base, int ways, int w, int older);
        for (int v = 0; v < ways; v++) begin
            if (v != w && valid_mem[base+v] && rank_mem[base+v] < older &&
                rank_mem[base+v] < WAYS_MAX - 1)
                rank_mem[base+v] = rank_mem[base+v] + 1;
        end
        rank_mem[base+w] = 0;
    endfunction

    function automatic t_access_res predict_access(logic is_store, logic [31:0] addr);
        t_access_res r;
        int sb, ways, bb, base, found, free_way, slot, best;
        logic [63:0] xfer, cost, set_idx, tag;
        logic hit, wb;
        sb   = (set_bits_r > 8) ? 8 : set_bits_r;
        ways = (ways_r == 0) ? 1 : ((ways_r > WAYS_MAX) ? WAYS_MAX : ways_r);
        bb   = (block_bits_r < 2) ? 2 : ((block_bits_r > 10) ? 10 : block_bits_r);
        xfer = ((64'd1 << bb) >> 2) * 100;
        set_idx = ({32'd0, addr} >> bb) & ((64'd1 << sb) - 1);
        tag  = {32'd0, addr} >> (bb + sb);
        base = int'(set_idx) * WAYS_MAX;
        found = ways;
        free_way = ways;
        hit = 0;
        wb = 0;
        for (int w = 0; w < ways; w++) begin
            if (valid_mem[base+w]) begin
                if (found == ways && tag_mem[base+w] == tag) found = w;
            end else if (free_way == ways) begin
                free_way = w;
            end
        end
        if (found < ways) begin
            hit = 1;
            make_recent(base, ways, found, rank_mem[base+found]);
            if (!is_store) cost = 1;
            else if (wthrough_r) cost = xfer + 1;
            else begin
                dirty_mem[base+found] = 1;
                cost = 2;
            end
        end else if (is_store && !walloc_r) begin
            cost = xfer + 1;
        end else begin
            slot = free_way;
            if (slot == ways) begin
                best = 0;
                slot = 0;
                for (int w = 0; w < ways; w++) begin
                    if (valid_mem[base+w] && rank_mem[base+w] > best) begin
                        best = rank_mem[base+w];
                        slot = w;
                    end
                end
            end
            cost = xfer + 2;
            if (free_way == ways && !wthrough_r && dirty_mem[base+slot]) begin
                wb = 1;
                cost = cost + xfer;
            end
            if (is_store && wthrough_r) cost = cost + xfer;
            tag_mem[base+slot] = tag;
            valid_mem[base+slot] = 1;
            dirty_mem[base+slot] = is_store && !wthrough_r;
            make_recent(base, ways, slot, WAYS_MAX);
        end
        if (is_store) begin
            bump_count(3);
            bump_count(hit ? 4 : 5);
        end else begin
            bump_count(0);
            bump_count(hit ? 1 : 2);
        end
        if ({16'd0, SUM_SAT - cycle_sum} < cost) cycle_sum = SUM_SAT;
        else cycle_sum = cycle_sum + cost[47:0];
        r.hit = hit;
        r.cost = cost[15:0];
        r.wb = wb;
        r.total = cycle_sum;
        for (int k = 0; k < 6; k++) r.cnt[k] = acc_cnt[k];
        return r;
    endfunction

    function automatic int check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_access_res e;
        int bad;
        string cnt_names [6];
        cnt_names = '{"load_total", "load_hit_total", "load_miss_total",
                      "store_total", "store_hit_total", "store_miss_total"};
        if (!i_rst_n) begin
            set_bits_r   <= RST_SET_BITS;
            ways_r       <= RST_WAYS;
            block_bits_r <= RST_BLOCK_BITS;
            walloc_r     <= 1'b1;
            wthrough_r   <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                valid_mem[i] = 0;
                dirty_mem[i] = 0;
                rank_mem[i]  = 0;
                tag_mem[i]   = 0;
            end
            cycle_sum = 0;
            for (int k = 0; k < 6; k++) acc_cnt[k] = 0;
            expected_q.delete();
            o_errors <= 0;
            o_results <= 0;
            o_hits <= 0;
            o_writebacks <= 0;
        end else begin
            bad = 0;
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no access outstanding");
                    bad++;
                end else begin
                    e = expected_q.pop_front();
                    bad += check_field("hit", e.hit, m_axis_tdata[0]);
                    bad += check_field("cycles_added", e.cost, m_axis_tdata[16:1]);
                    bad += check_field("dirty_writeback", e.wb, m_axis_tdata[17]);
                    bad += check_field("total_cycles", e.total, m_axis_tdata[65:18]);
                    for (int k = 0; k < 6; k++)
                        bad += check_field(cnt_names[k], e.cnt[k],
                                           m_axis_tdata[66+32*k +: 32]);
                    o_hits <= o_hits + e.hit;
                    o_writebacks <= o_writebacks + e.wb;
                end
                o_results <= o_results + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict_access(s_axis_tuser, s_axis_tdata));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:   set_bits_r   <= i_cfg_data;
                    CFG_WAYS:       ways_r       <= i_cfg_data;
                    CFG_BLOCK_BITS: block_bits_r <= i_cfg_data;
                    CFG_WALLOC:     walloc_r     <= i_cfg_data[0];
                    CFG_WTHROUGH:   wthrough_r   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            o_errors <= o_errors + bad;
        end
        o_pending <= expected_q.size();
    end
endmodule
`default_nettype wire

// ===== tb/sv/lru_set_assoc_cache_model_tb.sv =====
// testbench top for the lru cache model: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
`default_nettype none
module lru_set_assoc_cache_model_tb;
    import lrc_pkg::*;

    localparam logic ACC_LOAD  = 1'b0;
    localparam logic ACC_STORE = 1'b1;
    localparam int   CYCLE_LIMIT = 1000000;
    localparam int   NUM_PHASES = 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors, pending, results, hits, writebacks;
    int cycle_cnt = 0;
    int accesses = 0;
    bit stall_on = 1'b1;
    bit gaps_on = 1'b1;
    int stall_len = 0;

    always #2 i_clk = ~i_clk;

    lru_set_assoc_cache_model u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    lru_set_assoc_cache_model_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_hits(hits), .o_writebacks(writebacks)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver back-pressure in runs, mostly short
    always @(posedge i_clk) begin
        if (stall_len > 0) begin
            stall_len <= stall_len - 1;
        end else if (!stall_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 2) != 0);
            stall_len <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end
    end

    task automatic send_access(logic kind, logic [31:0] addr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!s_axis_tready);
        accesses++;
        gap = 0;
        if (gaps_on && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(logic [3:0] sb, logic [3:0] ways, logic [3:0] bb,
                                logic walloc, logic wthrough);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [3:0] val [5];
        idx = '{CFG_SET_BITS, CFG_WAYS, CFG_BLOCK_BITS, CFG_WALLOC, CFG_WTHROUGH};
        val = '{sb, ways, bb, {3'd0, walloc}, {3'd0, wthrough}};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_address();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return ($urandom_range(0, 15) << 20) ^ ($urandom_range(0, 7) << 10)
               ^ $urandom_range(0, 1023) ^ (32'($urandom_range(0, 1)) << 31);
    endfunction

    initial begin
        logic [3:0] ph_sb [NUM_PHASES];
        logic [3:0] ph_ways [NUM_PHASES];
        logic [3:0] ph_bb [NUM_PHASES];
        logic ph_wa [NUM_PHASES];
        logic ph_wt [NUM_PHASES];
        ph_sb   = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd2, 4'd4};
        ph_ways = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd8};
        ph_bb   = '{4'd2, 4'd10, 4'd0, 4'd15, 4'd5, 4'd3};
        ph_wa   = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        ph_wt   = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: 64 sets, 4 ways, 16-byte blocks, write-back allocate
        send_access(ACC_LOAD, 32'h0000_0000);
        send_access(ACC_LOAD, 32'h0000_000C);
        send_access(ACC_STORE, 32'h0000_0004);
        for (int t = 1; t <= 4; t++) send_access(ACC_LOAD, t << 10);
        send_access(ACC_STORE, 32'h0000_5000);
        for (int t = 6; t <= 9; t++) send_access(ACC_STORE, t << 10);
        send_access(ACC_LOAD, 32'hFFFF_FFFF);
        send_access(ACC_STORE, 32'hFFFF_FFF0);
        wait_idle();
        write_config(4'd6, 4'd4, 4'd4, 1'b0, 1'b1);
        send_access(ACC_STORE, 32'h0000_0000);
        send_access(ACC_STORE, 32'h0001_0000);
        send_access(ACC_LOAD, 32'h0001_0000);
        send_access(ACC_STORE, 32'h0001_0000);
        send_access(ACC_LOAD, 32'hAAAA_5555);
        wait_idle();
        write_config(4'd6, 4'd4, 4'd4, 1'b1, 1'b1);
        send_access(ACC_STORE, 32'h0002_0000);
        send_access(ACC_STORE, 32'h5555_AAAA);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_config(ph_sb[p], ph_ways[p], ph_bb[p], ph_wa[p], ph_wt[p]);
            stall_on = (p % 3 != 2);
            gaps_on  = (p % 3 != 1);
            for (int n = 0; n < 280; n++)
                send_access(logic'($urandom_range(0, 1)), pick_address());
        end
        wait_idle();
        repeat (20) @(posedge i_clk);

        $display("ran %0d accesses over %0d configuration phases", accesses, NUM_PHASES + 3);
        $display("%0d results checked, %0d hits, %0d dirty write-backs",
                 results, hits, writebacks);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
src/lrc_pkg.sv
src/lrc_tag_ram.sv
src/lrc_set_update.sv
src/lru_set_assoc_cache_model.sv
src/lrc_checker.sv
tb/sv/lru_set_assoc_cache_model_checker.sv
tb/sv/lru_set_assoc_cache_model_tb.sv
